// ===== src/lcdfmt_pkg.sv =====
// Shared types, constants and digit helpers for the LCD segment formatter.
`default_nettype none

package lcdfmt_pkg;

  localparam int unsigned InWidth   = 32;
  localparam int unsigned OutWidth  = 32;
  localparam int unsigned AddrWidth = 6;

  typedef enum logic [1:0] {
    ACT_ADDRESS  = 2'd0,
    ACT_READINGS = 2'd1,
    ACT_ALL_ON   = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  localparam logic [AddrWidth-1:0] SEG_ADDR_LOW  = 6'd0;
  localparam logic [AddrWidth-1:0] SEG_ADDR_HIGH = 6'd13;

  localparam logic [7:0] DP_BIT      = 8'h80;
  localparam logic [7:0] T_BIT       = 8'h08;
  localparam logic [7:0] MINUS_GLYPH = 8'h20;
  localparam logic [7:0] GLYPH_D     = 8'hE6;
  localparam logic [7:0] GLYPH_A     = 8'h77;
  localparam logic [7:0] ALL_ON      = 8'hFF;
  localparam logic [7:0] BLANK       = 8'h00;

  localparam logic [11:0] SAT_POS = 12'd999;
  localparam logic [11:0] SAT_NEG = 12'd99;

  typedef struct packed {
    logic [AddrWidth-1:0] seg_address;
    logic [7:0]           seg_byte_first;
    logic [7:0]           seg_byte_second;
    logic [7:0]           seg_byte_third;
    logic                 last;
  } frame_t;

  typedef struct packed {
    frame_t first;
    frame_t second;
  } frame_pair_t;

  // glyph table for the humidity and address digits
  function automatic logic [7:0] digit_one(input logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'd0: g = 8'h7D;
      4'd1: g = 8'h60;
      4'd2: g = 8'h3E;
      4'd3: g = 8'h7A;
      4'd4: g = 8'h63;
      4'd5: g = 8'h5B;
      4'd6: g = 8'h5F;
      4'd7: g = 8'h70;
      4'd8: g = 8'h7F;
      4'd9: g = 8'h7B;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  // glyph table for the temperature digits
  function automatic logic [7:0] digit_two(input logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'd0: g = 8'hD7;
      4'd1: g = 8'h06;
      4'd2: g = 8'hE3;
      4'd3: g = 8'hA7;
      4'd4: g = 8'h36;
      4'd5: g = 8'hB5;
      4'd6: g = 8'hF5;
      4'd7: g = 8'h07;
      4'd8: g = 8'hF7;
      4'd9: g = 8'hB7;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  // v / 100 for v below 1000: v * 41 / 4096
  function automatic logic [3:0] hundreds_of(input logic [9:0] v);
    logic [15:0] p;
    p = {6'd0, v} * 16'd41;
    return p[15:12];
  endfunction

  function automatic logic [6:0] rem_hundred(input logic [9:0] v, input logic [3:0] h);
    logic [9:0] r;
    r = v - ({6'd0, h} * 10'd100);
    return r[6:0];
  endfunction

  // r / 10 for r below 100: r * 205 / 2048
  function automatic logic [3:0] tens_of(input logic [6:0] r);
    logic [14:0] p;
    p = {8'd0, r} * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [6:0] r, input logic [3:0] t);
    logic [6:0] x;
    x = r - ({3'd0, t} * 7'd10);
    return x[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/lcdfmt_frame_out.sv =====
// Output register pair: sends the two frames of one request in turn.
`default_nettype none

module lcdfmt_frame_out
  import lcdfmt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load_valid,
  output logic             load_ready,
  input  wire frame_pair_t load_frames,
  output logic             out_valid,
  input  wire logic        out_ready,
  output frame_t           out_frame
);

  frame_pair_t frames;
  logic        busy;
  logic        phase;   // 0: first frame showing, 1: second

  logic load;
  logic take;

  assign take       = busy && out_ready;
  assign load_ready = !busy || (out_ready && phase);
  assign load       = load_valid && load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (load) begin
      busy  <= 1'b1;
      phase <= 1'b0;
    end else if (take) begin
      if (!phase) begin
        phase <= 1'b1;
      end else begin
        busy  <= 1'b0;
        phase <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frames <= load_frames;
    end
  end

  assign out_valid = busy;
  assign out_frame = phase ? frames.second : frames.first;

endmodule

`default_nettype wire

// ===== src/lcd_reading_segment_formatter.sv =====
// Top level: pipelined decimal split and segment encoding of display requests.
`default_nettype none

// Channel    Dir  Transaction
// s_axis     in   one request: action, humidity_tenths, temp_tenths
// m_axis     out  one frame: segment address and three bytes, tlast on the second
// cfg        in   station_address write, taken at any cycle outside reset
//
// Four register stages (input/saturate, hundreds, tens and ones, glyph lookup)
// feed an output register pair; a taken request moves through the stages in
// order and is then loaded into the pair. Each request yields two frames; the
// pair loads a new request only when empty or as its second frame is taken.
// "No output" requests are dropped on entry and take no slot.
// rst is synchronous and clears valid bits and station_address (to 1); no
// transaction is taken on either input channel while it is high.
// Back-pressure on m_axis stalls each stage only while it holds an item.

module lcd_reading_segment_formatter
  import lcdfmt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [1:0] action, [13:2] humidity_tenths, [25:14] temp_tenths, [31:26] zero
  input  wire logic [InWidth-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [5:0] seg_address, [13:6] seg_byte_first, [21:14] seg_byte_second,
  // [29:22] seg_byte_third, [31:30] zero
  output logic [OutWidth-1:0]      m_axis_tdata,
  output logic                     m_axis_tlast,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [7:0]          cfg_data
);

  // configuration register
  logic [7:0] station_address;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= 8'd1;
    end else if (cfg_valid) begin
      station_address <= cfg_data;
    end
  end

  // input unpack and saturation
  action_t     in_action;
  logic [11:0] in_hum;
  logic [11:0] in_temp;
  logic        in_neg;
  logic [11:0] in_mag;
  logic [9:0]  hum_sat;
  logic [9:0]  mag_sat;

  always_comb begin
    in_action = action_t'(s_axis_tdata[1:0]);
    in_hum    = s_axis_tdata[13:2];
    in_temp   = s_axis_tdata[25:14];
    in_neg    = in_temp[11];
    in_mag    = in_neg ? (~in_temp + 12'd1) : in_temp;
    hum_sat   = (in_hum > SAT_POS) ? SAT_POS[9:0] : in_hum[9:0];
    if (in_neg) begin
      mag_sat = (in_mag > SAT_NEG) ? SAT_NEG[9:0] : in_mag[9:0];
    end else begin
      mag_sat = (in_mag > SAT_POS) ? SAT_POS[9:0] : in_mag[9:0];
    end
  end

  // pipeline handshake: a stage moves when empty or when the next one moves
  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;
  logic out_load_ready;

  assign r4 = !v4 || out_load_ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign s_axis_tready = r1 && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= s_axis_tvalid && (in_action != ACT_NONE);
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  // stage 1: saturated values
  action_t    s1_action;
  logic       s1_neg;
  logic [9:0] s1_hum;
  logic [9:0] s1_mag;
  logic [7:0] s1_addr;

  always_ff @(posedge clk) begin
    if (r1) begin
      s1_action <= in_action;
      s1_neg    <= in_neg;
      s1_hum    <= hum_sat;
      s1_mag    <= mag_sat;
      s1_addr   <= station_address;
    end
  end

  // stage 2: hundreds and remainders
  action_t    s2_action;
  logic       s2_neg;
  logic [3:0] s2_hum_h;
  logic [3:0] s2_tmp_h;
  logic [6:0] s2_hum_r;
  logic [6:0] s2_tmp_r;
  logic [6:0] s2_adr_r;
  logic [3:0] hum_h;
  logic [3:0] tmp_h;
  logic [3:0] adr_h;

  assign hum_h = hundreds_of(s1_hum);
  assign tmp_h = hundreds_of(s1_mag);
  assign adr_h = hundreds_of({2'd0, s1_addr});

  always_ff @(posedge clk) begin
    if (r2) begin
      s2_action <= s1_action;
      s2_neg    <= s1_neg;
      s2_hum_h  <= hum_h;
      s2_tmp_h  <= tmp_h;
      s2_hum_r  <= rem_hundred(s1_hum, hum_h);
      s2_tmp_r  <= rem_hundred(s1_mag, tmp_h);
      s2_adr_r  <= rem_hundred({2'd0, s1_addr}, adr_h);
    end
  end

  // stage 3: tens and ones
  action_t    s3_action;
  logic       s3_neg;
  logic [3:0] s3_hum_h, s3_hum_t, s3_hum_o;
  logic [3:0] s3_tmp_h, s3_tmp_t, s3_tmp_o;
  logic [3:0] s3_adr_t, s3_adr_o;
  logic [3:0] hum_t, tmp_t, adr_t;

  assign hum_t = tens_of(s2_hum_r);
  assign tmp_t = tens_of(s2_tmp_r);
  assign adr_t = tens_of(s2_adr_r);

  always_ff @(posedge clk) begin
    if (r3) begin
      s3_action <= s2_action;
      s3_neg    <= s2_neg;
      s3_hum_h  <= s2_hum_h;
      s3_hum_t  <= hum_t;
      s3_hum_o  <= ones_of(s2_hum_r, hum_t);
      s3_tmp_h  <= s2_tmp_h;
      s3_tmp_t  <= tmp_t;
      s3_tmp_o  <= ones_of(s2_tmp_r, tmp_t);
      s3_adr_t  <= adr_t;
      s3_adr_o  <= ones_of(s2_adr_r, adr_t);
    end
  end

  // stage 4: glyph lookup and frame build
  frame_pair_t frames_next;
  frame_pair_t s4_frames;

  always_comb begin
    frames_next.first.seg_address  = SEG_ADDR_LOW;
    frames_next.first.last         = 1'b0;
    frames_next.second.seg_address = SEG_ADDR_HIGH;
    frames_next.second.last        = 1'b1;
    unique case (s3_action)
      ACT_ADDRESS: begin
        frames_next.first.seg_byte_first   = BLANK;
        frames_next.first.seg_byte_second  = digit_one(s3_adr_t);
        frames_next.first.seg_byte_third   = digit_one(s3_adr_o);
        frames_next.second.seg_byte_first  = GLYPH_D;
        frames_next.second.seg_byte_second = GLYPH_D;
        frames_next.second.seg_byte_third  = GLYPH_A;
      end
      ACT_READINGS: begin
        frames_next.first.seg_byte_first   = digit_one(s3_hum_h);
        frames_next.first.seg_byte_second  = digit_one(s3_hum_t) | DP_BIT;
        frames_next.first.seg_byte_third   = digit_one(s3_hum_o);
        frames_next.second.seg_byte_first  = digit_two(s3_tmp_o) | T_BIT;
        frames_next.second.seg_byte_second = digit_two(s3_tmp_t) | T_BIT;
        frames_next.second.seg_byte_third  = s3_neg ? (MINUS_GLYPH | T_BIT)
                                                    : (digit_two(s3_tmp_h) | T_BIT);
      end
      default: begin
        // all segments lit; "no output" never reaches this stage
        frames_next.first.seg_byte_first   = ALL_ON;
        frames_next.first.seg_byte_second  = ALL_ON;
        frames_next.first.seg_byte_third   = ALL_ON;
        frames_next.second.seg_byte_first  = ALL_ON;
        frames_next.second.seg_byte_second = ALL_ON;
        frames_next.second.seg_byte_third  = ALL_ON;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (r4) begin
      s4_frames <= frames_next;
    end
  end

  // output register pair
  frame_t out_frame;

  lcdfmt_frame_out u_frame_out (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (v4),
    .load_ready  (out_load_ready),
    .load_frames (s4_frames),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_frame   (out_frame)
  );

  assign m_axis_tdata = {2'b00, out_frame.seg_byte_third, out_frame.seg_byte_second,
                         out_frame.seg_byte_first, out_frame.seg_address};
  assign m_axis_tlast = out_frame.last;

endmodule

`default_nettype wire
